// ===== rtl/ini_parameter_lookup_parser_macros.svh =====
// ----------------------------------------------------------------------------
// ini parameter lookup parser: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INI_PARAMETER_LOOKUP_PARSER_MACROS_SVH
`define INI_PARAMETER_LOOKUP_PARSER_MACROS_SVH

// same-cycle implication
`define IPLP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IPLP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/iplp_pkg.sv =====
// ----------------------------------------------------------------------------
// iplp_pkg
// Types, character codes and result codes for the ini parameter lookup parser.
// ----------------------------------------------------------------------------
`default_nettype none

package iplp_pkg;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  value_byte;
		logic [15:0] value_offset;
		logic        final_result;
	} out_t;

	typedef enum logic [2:0] {
		PH_SEEK,
		PH_NAME,
		PH_BODY,
		PH_VALUE,
		PH_DONE
	} phase_t;

	localparam logic [1:0] ST_VALUE_BYTE = 2'd0;
	localparam logic [1:0] ST_VALUE_DONE = 2'd1;
	localparam logic [1:0] ST_NO_SECTION = 2'd2;
	localparam logic [1:0] ST_NO_PARAM   = 2'd3;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SECTION_NAME   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SECTION_LENGTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PARAMETER_NUM  = 2'd2;
	localparam int CFG_DATA_W = 64;

	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_EQUALS   = 8'h3D;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;

	localparam logic [3:0]  NAME_CNT_MAX = 4'd15;
	localparam logic [15:0] EQ_CNT_MAX   = 16'hFFFF;

	function automatic out_t make_result(logic [1:0] st, logic [7:0] vb,
		logic [15:0] ofs, logic fin);
		out_t r;
		r.status       = st;
		r.value_byte   = vb;
		r.value_offset = ofs;
		r.final_result = fin;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ini_parameter_lookup_parser.sv =====
// A text beat is registered in the input stage, and its results are then written
// into the result queue and offered from there. Throughput: one text beat per
// cycle while the input does not stall; a value byte marked last yields two results
// at once. The input stalls only while more than two results wait in the four-entry
// result queue, which decouples the output stall. Reset clears the lookup state,
// the queue and the registers to their defaults (empty name, length 0, parameter number 1).
// ----------------------------------------------------------------------------
// ini_parameter_lookup_parser
// Streams a settings text, finds the configured section and parameter and
// returns the value bytes, its start offset and the lookup status.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ini_parameter_lookup_parser_macros.svh"

module ini_parameter_lookup_parser #(
	parameter int NAME_BYTES  = 8,
	parameter int OFFSET_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [iplp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [iplp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire iplp_pkg::in_t                      in_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output iplp_pkg::out_t                          out_data
);
	import iplp_pkg::*;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = 2;
	localparam int CNT_W      = 3;

	// configuration registers
	logic [7:0]  name_q [NAME_BYTES];
	logic [3:0]  name_len_q;
	logic [15:0] param_num_q;

	// input stage
	logic valid_s1;
	in_t  data_s1;
	logic s1_adv;

	// lookup state
	phase_t                 phase_q, phase_d;
	logic [OFFSET_BITS-1:0] text_ofs_q, text_ofs_d;
	logic                   match_q, match_d;
	logic [3:0]             name_cnt_q, name_cnt_d;
	logic [15:0]            eq_cnt_q, eq_cnt_d;
	logic [OFFSET_BITS-1:0] val_start_q, val_start_d;

	// results of the current beat
	out_t       res_c [2];
	logic [1:0] nres;

	logic [7:0]  cur_byte;
	logic        end_s1;
	logic [15:0] eq_inc;
	logic [7:0]  name_sel;
	logic        name_found;
	logic        name_hit;

	// result queue
	out_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign s1_adv   = valid_s1 && (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign in_stall = valid_s1 && !s1_adv;
	assign pop      = out_valid && !out_stall;
	assign out_valid = (count_q != '0);
	assign out_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NAME_BYTES; k++) begin
				name_q[k] <= '0;
			end
			name_len_q  <= '0;
			param_num_q <= 16'd1;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SECTION_NAME: begin
					for (int k = 0; k < NAME_BYTES; k++) begin
						name_q[k] <= cfg_data[8*k +: 8];
					end
				end
				CFG_SECTION_LENGTH: name_len_q  <= cfg_data[3:0];
				CFG_PARAMETER_NUM:  param_num_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	// section name byte at the current name position
	always_comb begin
		name_sel   = '0;
		name_found = 1'b0;
		for (int k = 0; k < NAME_BYTES; k++) begin
			if (name_cnt_q == 4'(k)) begin
				name_sel   = name_q[k];
				name_found = 1'b1;
			end
		end
	end

	assign cur_byte = data_s1.text_byte;
	assign end_s1   = (cur_byte == CH_NUL) || data_s1.last_byte;
	assign eq_inc   = (eq_cnt_q == EQ_CNT_MAX) ? eq_cnt_q : eq_cnt_q + 16'd1;
	assign name_hit = (name_cnt_q < name_len_q) && name_found && (name_sel == cur_byte);

	always_comb begin
		phase_d     = phase_q;
		text_ofs_d  = text_ofs_q;
		match_d     = match_q;
		name_cnt_d  = name_cnt_q;
		eq_cnt_d    = eq_cnt_q;
		val_start_d = val_start_q;
		res_c[0]    = '0;
		res_c[1]    = '0;
		nres        = '0;

		case (phase_q)
			PH_SEEK: begin
				if (cur_byte == CH_LBRACKET) begin
					phase_d    = PH_NAME;
					match_d    = 1'b1;
					name_cnt_d = '0;
				end
			end
			PH_NAME: begin
				if (cur_byte == CH_NUL) begin
					// end of text handled below
				end else if (cur_byte == CH_RBRACKET) begin
					if (match_q && (name_cnt_q == name_len_q)) begin
						phase_d  = PH_BODY;
						eq_cnt_d = '0;
					end else if (name_cnt_q == '0) begin
						res_c[nres[0]] = make_result(ST_NO_SECTION, '0, '0, 1'b1);
						nres           = nres + 2'd1;
						phase_d        = PH_DONE;
					end else begin
						phase_d = PH_SEEK;
					end
				end else begin
					if (!name_hit) begin
						match_d = 1'b0;
					end
					if (name_cnt_q != NAME_CNT_MAX) begin
						name_cnt_d = name_cnt_q + 4'd1;
					end
				end
			end
			PH_BODY: begin
				if (cur_byte == CH_LBRACKET || cur_byte == CH_NUL) begin
					res_c[nres[0]] = make_result(ST_NO_PARAM, '0, '0, 1'b1);
					nres           = nres + 2'd1;
					phase_d        = PH_DONE;
				end else if (cur_byte == CH_EQUALS) begin
					eq_cnt_d = eq_inc;
					if (eq_inc == param_num_q) begin
						phase_d     = PH_VALUE;
						val_start_d = text_ofs_q + OFFSET_BITS'(1);
					end
				end
			end
			PH_VALUE: begin
				if (cur_byte == CH_NUL || cur_byte == CH_LBRACKET || cur_byte == CH_CR ||
					cur_byte == CH_LF || cur_byte == CH_SEMI) begin
					res_c[nres[0]] = make_result(ST_VALUE_DONE, '0, 16'(val_start_q), 1'b1);
					nres           = nres + 2'd1;
					phase_d        = PH_DONE;
				end else begin
					res_c[nres[0]] = make_result(ST_VALUE_BYTE, cur_byte, '0, 1'b0);
					nres           = nres + 2'd1;
				end
			end
			default: ;
		endcase

		if (end_s1) begin
			case (phase_d)
				PH_SEEK, PH_NAME: begin
					res_c[nres[0]] = make_result(ST_NO_SECTION, '0, '0, 1'b1);
					nres           = nres + 2'd1;
				end
				PH_BODY: begin
					res_c[nres[0]] = make_result(ST_NO_PARAM, '0, '0, 1'b1);
					nres           = nres + 2'd1;
				end
				PH_VALUE: begin
					res_c[nres[0]] = make_result(ST_VALUE_DONE, '0, 16'(val_start_d), 1'b1);
					nres           = nres + 2'd1;
				end
				default: ;
			endcase
			phase_d     = PH_SEEK;
			text_ofs_d  = '0;
			match_d     = 1'b1;
			name_cnt_d  = '0;
			eq_cnt_d    = '0;
			val_start_d = '0;
		end else begin
			text_ofs_d = text_ofs_q + OFFSET_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SEEK;
			text_ofs_q  <= '0;
			match_q     <= 1'b1;
			name_cnt_q  <= '0;
			eq_cnt_q    <= '0;
			val_start_q <= '0;
		end else if (s1_adv) begin
			phase_q     <= phase_d;
			text_ofs_q  <= text_ofs_d;
			match_q     <= match_d;
			name_cnt_q  <= name_cnt_d;
			eq_cnt_q    <= eq_cnt_d;
			val_start_q <= val_start_d;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (s1_adv) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(nres);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (s1_adv ? CNT_W'(nres) : '0) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && nres != 2'd0) begin
			fifo_q[wr_ptr_q] <= res_c[0];
		end
		if (s1_adv && nres == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= res_c[1];
		end
	end

	`IPLP_ASSERT_NOW(a_fifo_bound, 1'b1, count_q <= CNT_W'(FIFO_DEPTH), "result queue overflow")
	`IPLP_ASSERT_NOW(a_two_only_at_end, s1_adv && nres == 2'd2, end_s1, "two results without text end")
	`IPLP_ASSERT_NEXT(a_end_clears_offset, s1_adv && end_s1, text_ofs_q == '0 && phase_q == PH_SEEK, "text end did not clear lookup")
	`IPLP_ASSERT_NEXT(a_done_holds, s1_adv && phase_q == PH_DONE, phase_q == PH_DONE || phase_q == PH_SEEK, "closed lookup reopened")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: ini parameter lookup parser testbench
// Streams settings texts into the parser and checks every result beat against
// a behavioural predictor of the section and parameter search, under several
// register settings and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	import iplp_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_PHASES  = 8;
	localparam int BEATS_PER_PHASE = 166;
	localparam int LONG_HOLD      = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	in_t                    in_data   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_t                   out_data;

	ini_parameter_lookup_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies
	logic [63:0] name_cfg     = '0;
	logic [3:0]  name_len_cfg = '0;
	logic [15:0] param_cfg    = 16'd1;

	// search state
	phase_t      scan_phase  = PH_SEEK;
	logic [15:0] text_ofs    = '0;
	logic        name_ok     = 1'b1;
	logic [3:0]  name_cnt    = '0;
	logic [15:0] eq_cnt      = '0;
	logic [15:0] value_start = '0;

	in_t  text_buf[$];
	in_t  pending_beats[$];
	out_t lookup_results_due[$];

	int   send_gap_pct = 0;
	int   stall_pct    = 0;
	int   hold_left    = 0;
	logic hold_req     = 1'b0;
	logic hold_taken   = 1'b0;
	int   idle_cycles  = 0;

	int mismatches       = 0;
	int texts_sent       = 0;
	int beats_sent       = 0;
	int results_checked  = 0;
	int values_found     = 0;
	int sections_missing = 0;
	int params_missing   = 0;

	function automatic void expect_result(logic [1:0] st, logic [7:0] vb, logic [15:0] ofs,
		logic fin);
		out_t r;
		r.status       = st;
		r.value_byte   = vb;
		r.value_offset = ofs;
		r.final_result = fin;
		lookup_results_due.push_back(r);
	endfunction

	function automatic void scan_text_byte(in_t beat);
		logic [7:0]  b;
		logic        at_end;
		logic [15:0] off;
		logic        hit;
		b = beat.text_byte;
		at_end = (b == CH_NUL) || beat.last_byte;
		off = text_ofs;
		case (scan_phase)
		PH_SEEK: begin
			if (b == CH_LBRACKET) begin
				scan_phase = PH_NAME;
				name_ok = 1'b1;
				name_cnt = '0;
			end
		end
		PH_NAME: begin
			if (b == CH_NUL) begin
			end else if (b == CH_RBRACKET) begin
				if (name_ok && name_cnt == name_len_cfg) begin
					scan_phase = PH_BODY;
					eq_cnt = '0;
				end else if (name_cnt == 0) begin
					expect_result(ST_NO_SECTION, '0, '0, 1'b1);
					scan_phase = PH_DONE;
				end else begin
					scan_phase = PH_SEEK;
				end
			end else begin
				hit = 1'b0;
				if (name_cnt < name_len_cfg && name_cnt < 8)
					hit = (name_cfg[8*name_cnt +: 8] == b);
				if (!hit)
					name_ok = 1'b0;
				if (name_cnt != NAME_CNT_MAX)
					name_cnt = name_cnt + 1'b1;
			end
		end
		PH_BODY: begin
			if (b == CH_LBRACKET || b == CH_NUL) begin
				expect_result(ST_NO_PARAM, '0, '0, 1'b1);
				scan_phase = PH_DONE;
			end else if (b == CH_EQUALS) begin
				if (eq_cnt != EQ_CNT_MAX)
					eq_cnt = eq_cnt + 1'b1;
				if (eq_cnt == param_cfg) begin
					scan_phase = PH_VALUE;
					value_start = off + 1'b1;
				end
			end
		end
		PH_VALUE: begin
			if (b == CH_NUL || b == CH_LBRACKET || b == CH_CR || b == CH_LF || b == CH_SEMI)
			begin
				expect_result(ST_VALUE_DONE, '0, value_start, 1'b1);
				scan_phase = PH_DONE;
			end else begin
				expect_result(ST_VALUE_BYTE, b, '0, 1'b0);
			end
		end
		default: begin
		end
		endcase
		if (at_end) begin
			if (scan_phase == PH_SEEK || scan_phase == PH_NAME)
				expect_result(ST_NO_SECTION, '0, '0, 1'b1);
			else if (scan_phase == PH_BODY)
				expect_result(ST_NO_PARAM, '0, '0, 1'b1);
			else if (scan_phase == PH_VALUE)
				expect_result(ST_VALUE_DONE, '0, value_start, 1'b1);
			scan_phase = PH_SEEK;
			text_ofs = '0;
			name_ok = 1'b1;
			name_cnt = '0;
			eq_cnt = '0;
			value_start = '0;
		end else begin
			text_ofs = off + 1'b1;
		end
	endfunction

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending_beats.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				in_data <= pending_beats.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			out_stall <= 1'b1;
			hold_left <= LONG_HOLD - 1;
			hold_taken <= 1'b1;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor and checker
	always @(posedge clk) begin : mon
		out_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				scan_text_byte(in_data);
			if (out_valid && !out_stall) begin
				if (lookup_results_due.size() == 0) begin
					$error("result beat with none expected: status %0d, byte %0d, offset %0d",
						out_data.status, out_data.value_byte, out_data.value_offset);
					mismatches++;
				end else begin
					want = lookup_results_due.pop_front();
					results_checked++;
					if (out_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_data.status);
						mismatches++;
					end
					if (out_data.value_byte !== want.value_byte) begin
						$error("value_byte: expected %0d, got %0d", want.value_byte,
							out_data.value_byte);
						mismatches++;
					end
					if (out_data.value_offset !== want.value_offset) begin
						$error("value_offset: expected %0d, got %0d", want.value_offset,
							out_data.value_offset);
						mismatches++;
					end
					if (out_data.final_result !== want.final_result) begin
						$error("final_result: expected %0d, got %0d", want.final_result,
							out_data.final_result);
						mismatches++;
					end
					if (want.final_result) begin
						case (want.status)
						ST_VALUE_DONE: values_found++;
						ST_NO_SECTION: sections_missing++;
						ST_NO_PARAM: params_missing++;
						default: begin
						end
						endcase
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$error("no beat moved for %0d cycles, %0d results outstanding", WATCHDOG_LIMIT,
				lookup_results_due.size());
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic void put(logic [7:0] b);
		in_t t;
		t.text_byte = b;
		t.last_byte = 1'b0;
		text_buf.push_back(t);
	endfunction

	function automatic void put_last(logic [7:0] b);
		in_t t;
		t.text_byte = b;
		t.last_byte = 1'b1;
		text_buf.push_back(t);
	endfunction

	function automatic int commit_text();
		int n;
		n = text_buf.size();
		foreach (text_buf[i])
			pending_beats.push_back(text_buf[i]);
		text_buf.delete();
		texts_sent++;
		beats_sent += n;
		return n;
	endfunction

	function automatic logic [7:0] letter();
		return $urandom_range(1) ? 8'($urandom_range(8'h61, 8'h7A))
			: 8'($urandom_range(8'h41, 8'h5A));
	endfunction

	function automatic logic [7:0] value_char();
		logic [7:0] b;
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return CH_LBRACKET;
		if (r < 8)
			return CH_EQUALS;
		if (r < 18)
			return 8'($urandom_range(8'h80, 8'hFF));
		do
			b = 8'($urandom_range(8'h20, 8'h7E));
		while (b == CH_LBRACKET || b == CH_SEMI);
		return b;
	endfunction

	// one key line; returns 1 when the text was cut inside the value
	function automatic logic put_line();
		if ($urandom_range(9) == 0) begin
			put(CH_SEMI);
			repeat ($urandom_range(0, 4))
				put(letter());
			put(CH_CR);
			put(CH_LF);
			return 1'b0;
		end
		repeat ($urandom_range(0, 3))
			put(letter());
		put(CH_EQUALS);
		repeat ($urandom_range(0, 6))
			put(value_char());
		if ($urandom_range(19) == 0) begin
			text_buf[$].last_byte = 1'b1;
			return 1'b1;
		end
		case ($urandom_range(3))
		0: put(CH_LF);
		1: begin
			put(CH_CR);
			put(CH_LF);
		end
		2: begin
			put(CH_SEMI);
			put(letter());
			put(CH_LF);
		end
		default: put(CH_CR);
		endcase
		return 1'b0;
	endfunction

	function automatic int queue_text();
		logic [7:0] nm[$];
		logic       ended;
		int         r;
		int         pos;
		int         n_sec;
		int         n_lines;
		ended = 1'b0;
		text_buf.delete();
		if ($urandom_range(99) < 12) begin
			repeat ($urandom_range(1, 20))
				put(8'($urandom_range(1, 255)));
		end else begin
			if ($urandom_range(3) == 0)
				ended = put_line();
			n_sec = $urandom_range(1, 3);
			for (int s = 0; s < n_sec && !ended; s++) begin
				nm.delete();
				r = $urandom_range(99);
				if (r < 80) begin
					for (int i = 0; i < int'(name_len_cfg); i++)
						nm.push_back(i < 8 ? name_cfg[8*i +: 8] : letter());
					if (r >= 55 && r < 65) begin
						nm.push_back(letter());
					end else if (r >= 65 && r < 72 && nm.size() != 0) begin
						void'(nm.pop_back());
					end else if (r >= 72 && nm.size() != 0) begin
						pos = $urandom_range(0, nm.size() - 1);
						nm[pos] = nm[pos] ^ 8'h20;
					end
				end else if (r < 86) begin
					repeat ($urandom_range(12, 18))
						nm.push_back(letter());
				end else if (r < 90) begin
					nm.push_back(letter());
					nm.push_back(CH_LBRACKET);
					nm.push_back(letter());
				end else begin
					repeat ($urandom_range(0, 5))
						nm.push_back(letter());
				end
				put(CH_LBRACKET);
				foreach (nm[i])
					put(nm[i]);
				if ($urandom_range(24) == 0) begin
					put(CH_NUL);
					ended = 1'b1;
				end else begin
					put(CH_RBRACKET);
					put(CH_LF);
					n_lines = $urandom_range(0, 4);
					for (int l = 0; l < n_lines && !ended; l++)
						ended = put_line();
				end
			end
		end
		if (!ended) begin
			if ($urandom_range(1) == 0 || text_buf.size() == 0)
				put(CH_NUL);
			else
				text_buf[$].last_byte = 1'b1;
		end
		return commit_text();
	endfunction

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
		CFG_SECTION_NAME: name_cfg = val;
		CFG_SECTION_LENGTH: name_len_cfg = val[3:0];
		CFG_PARAMETER_NUM: param_cfg = val[15:0];
		default: begin
		end
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// block drained and quiet, so registers may change
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_beats.size() != 0 || in_valid || lookup_results_due.size() != 0);
		repeat (8)
			@(negedge clk);
	endtask

	int len_plan[RANDOM_PHASES]   = '{0, 8, 3, 15, 1, 5, 8, 2};
	int param_plan[RANDOM_PHASES] = '{1, 1, 2, 65535, 0, 3, 1, 2};
	int gap_plan[4]               = '{0, 46, 0, 17};
	int stall_plan[4]             = '{0, 0, 46, 17};

	initial begin
		logic [63:0] nm;
		int          n;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty name matches at reset; value cut by the last beat
		put(CH_LBRACKET);
		put(CH_RBRACKET);
		put(CH_EQUALS);
		put_last("v");
		void'(commit_text());
		// unterminated name
		put(CH_LBRACKET);
		put("x");
		put(CH_NUL);
		void'(commit_text());
		// no section at all
		put("a");
		put_last("b");
		void'(commit_text());
		// section ends before any equals sign
		put(CH_LBRACKET);
		put(CH_RBRACKET);
		put(CH_NUL);
		void'(commit_text());
		// empty value, then bytes after the lookup closed
		put(CH_LBRACKET);
		put(CH_RBRACKET);
		put(CH_EQUALS);
		put(CH_SEMI);
		put("z");
		put_last(8'hFF);
		void'(commit_text());
		wait_idle();

		// empty brackets with a non-empty target name
		write_reg(CFG_SECTION_NAME, 64'h6261);
		write_reg(CFG_SECTION_LENGTH, 64'd2);
		write_reg(CFG_PARAMETER_NUM, 64'd1);
		put(CH_LBRACKET);
		put(CH_RBRACKET);
		put_last("q");
		void'(commit_text());

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			send_gap_pct = gap_plan[p % 4];
			stall_pct = stall_plan[p % 4];
			for (int i = 0; i < 8; i++)
				nm[8*i +: 8] = letter();
			write_reg(CFG_SECTION_NAME, nm);
			write_reg(CFG_SECTION_LENGTH, 64'(len_plan[p]));
			write_reg(CFG_PARAMETER_NUM, 64'(param_plan[p]));
			n = 0;
			while (n < BEATS_PER_PHASE)
				n += queue_text();
			// receiver holds off while the sender keeps offering
			if (p == 0)
				hold_req = 1'b1;
		end
		wait_idle();

		$display("ran %0d texts, %0d text beats, over %0d register settings", texts_sent,
			beats_sent, RANDOM_PHASES + 2);
		$display("checked %0d results: %0d values found, %0d sections and %0d parameters missing",
			results_checked, values_found, sections_missing, params_missing);
		if (mismatches == 0 && lookup_results_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
